// ===== src/assert_macros.svh =====
// Assertion macros shared by the mains voltage and frequency qualifier RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ON(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== src/mvfq_pkg.sv =====
// Package for the mains voltage and frequency qualifier: widths, constants,
// payload structs, microcode encodings and sequencer status. No dependencies.
`timescale 1ns / 1ps

package mvfq_pkg;

  localparam int unsigned VsumW   = 20;
  localparam int unsigned CntW    = 8;
  localparam int unsigned PerW    = 10;
  localparam int unsigned VoltW   = 16;
  localparam int unsigned FreqW   = 18;
  localparam int unsigned GainW   = 16;
  localparam int unsigned CfgW    = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned RecW    = 7;
  localparam int unsigned EdcW    = 3;
  localparam int unsigned StepW   = 4;
  localparam int unsigned DivCntW = 5;
  localparam int unsigned ProdW   = VsumW + GainW;
  localparam int unsigned GainShift = 12;

  localparam logic [VsumW-1:0]   FreqNumerator = 20'd200000;
  localparam logic [DivCntW-1:0] DivSteps      = DivCntW'(VsumW);
  localparam logic [PerW-1:0]    AbsentPeriod  = 10'd600;
  localparam logic [RecW-1:0]    RecoveryWait  = 7'd60;
  localparam logic [RecW-1:0]    RecMax        = 7'd127;
  localparam logic [EdcW-1:0]    EdcMax        = 3'd7;
  localparam logic [EdcW-1:0]    EdcReload     = 3'd5;
  localparam logic [EdcW-1:0]    UpsLimit      = 3'd2;
  localparam logic [EdcW-1:0]    InvLimit      = 3'd1;

  localparam logic [FreqW-1:0] UpsCutFLo  = 18'd470;
  localparam logic [FreqW-1:0] UpsCutFHi  = 18'd530;
  localparam logic [FreqW-1:0] UpsRecFLo  = 18'd490;
  localparam logic [FreqW-1:0] UpsRecFHi  = 18'd510;
  localparam logic [FreqW-1:0] WideCutFLo = 18'd430;
  localparam logic [FreqW-1:0] WideCutFHi = 18'd570;
  localparam logic [FreqW-1:0] WideRecFLo = 18'd450;
  localparam logic [FreqW-1:0] WideRecFHi = 18'd550;

  localparam logic [VoltW-1:0] NarrowFbVLo = 16'd1850;
  localparam logic [VoltW-1:0] NarrowFbVHi = 16'd2550;
  localparam logic [VoltW-1:0] WideFbVLo   = 16'd1050;
  localparam logic [VoltW-1:0] WideFbVHi   = 16'd2850;

  localparam logic [CfgW-1:0]  UpsCutReset  = 32'd170395400;
  localparam logic [CfgW-1:0]  UpsRecReset  = 32'd163841900;
  localparam logic [CfgW-1:0]  InvCutReset  = 32'd190055400;
  localparam logic [CfgW-1:0]  InvRecReset  = 32'd183501900;
  localparam logic [CfgW-1:0]  ExtraReset   = 32'd58983200;
  localparam logic [GainW-1:0] GainReset    = 16'd4096;

  typedef enum logic [CfgIdxW-1:0] {
    RegUpsCut = 3'd0,
    RegUpsRec = 3'd1,
    RegInvCut = 3'd2,
    RegInvRec = 3'd3,
    RegExtra  = 3'd4,
    RegGain   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [VsumW-1:0] voltage_sum;
    logic [CntW-1:0]  sample_count;
    logic [PerW-1:0]  half_period;
    logic [PerW-1:0]  live_half_period;
    logic             inverter_select;
    logic             switch_on;
    logic             switch_condition;
    logic             second_tick;
  } in_t;

  typedef struct packed {
    logic [VoltW-1:0] voltage_reading;
    logic [FreqW-1:0] frequency_reading;
    logic             mains_good;
    logic             mains_on;
    logic             drop_to_inverter;
  } out_t;

  typedef enum logic [3:0] {
    OpNop      = 4'd0,
    OpTick     = 4'd1,
    OpDivFreq  = 4'd2,
    OpLoadFreq = 4'd3,
    OpDivMean  = 4'd4,
    OpLoadMean = 4'd5,
    OpGain     = 4'd6,
    OpFilter   = 4'd7,
    OpWindow   = 4'd8,
    OpFallback = 4'd9,
    OpEntry    = 4'd10,
    OpEmit     = 4'd11
  } op_t;

  typedef enum logic [2:0] {
    CondNext     = 3'd0,
    CondJump     = 3'd1,
    CondWaitItem = 3'd2,
    CondWaitDiv  = 3'd3,
    CondWaitOut  = 3'd4
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [StepW-1:0] target;
  } ctl_word_t;

  typedef struct packed {
    logic item_full;
    logic div_busy;
    logic out_blocked;
  } seq_status_t;

  localparam logic [StepW-1:0] LastStep = 4'd14;

endpackage

// ===== src/mvfq_div.sv =====
// Iterative restoring divider, one quotient bit per cycle, shared by the
// frequency and mean calculations. Depends on mvfq_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mvfq_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start_i,
  input  logic [mvfq_pkg::VsumW-1:0]  dividend_i,
  input  logic [mvfq_pkg::PerW-1:0]   divisor_i,
  output logic                        busy_o,
  output logic [mvfq_pkg::VsumW-1:0]  quot_o
);
  import mvfq_pkg::*;

  logic [DivCntW-1:0] cnt_r, cnt_nxt;
  logic [VsumW-1:0]   quot_r, quot_nxt;
  logic [PerW-1:0]    rem_r, rem_nxt;
  logic [PerW-1:0]    dsr_r, dsr_nxt;
  logic [PerW:0]      trial;
  logic [PerW:0]      diff;

  always_comb begin
    trial    = {rem_r, quot_r[VsumW-1]};
    diff     = trial - {1'b0, dsr_r};
    cnt_nxt  = cnt_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start_i) begin
      cnt_nxt  = DivSteps;
      quot_nxt = dividend_i;
      rem_nxt  = '0;
      dsr_nxt  = divisor_i;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt  = diff[PerW-1:0];
        quot_nxt = {quot_r[VsumW-2:0], 1'b1};
      end else begin
        rem_nxt  = trial[PerW-1:0];
        quot_nxt = {quot_r[VsumW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
  end

  assign busy_o = (cnt_r != '0);
  assign quot_o = quot_r;

  `ASSERT_NEVER(a_div_no_restart, start_i && busy_o, "Divider started while busy.")

endmodule

// ===== src/mvfq_seq.sv =====
// Microcode sequencer: step counter, control-word ROM, conditional waits and a jump.
// Depends on mvfq_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mvfq_seq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mvfq_pkg::seq_status_t status_i,
  output mvfq_pkg::op_t         op_o
);
  import mvfq_pkg::*;

  logic [StepW-1:0] step_r, step_nxt;
  ctl_word_t        cw;
  logic             hold;

  always_comb begin
    case (step_r)
      4'd0:    cw = '{OpNop,      CondWaitItem, '0};
      4'd1:    cw = '{OpTick,     CondNext,     '0};
      4'd2:    cw = '{OpDivFreq,  CondNext,     '0};
      4'd3:    cw = '{OpNop,      CondWaitDiv,  '0};
      4'd4:    cw = '{OpLoadFreq, CondNext,     '0};
      4'd5:    cw = '{OpDivMean,  CondNext,     '0};
      4'd6:    cw = '{OpNop,      CondWaitDiv,  '0};
      4'd7:    cw = '{OpLoadMean, CondNext,     '0};
      4'd8:    cw = '{OpGain,     CondNext,     '0};
      4'd9:    cw = '{OpFilter,   CondNext,     '0};
      4'd10:   cw = '{OpWindow,   CondNext,     '0};
      4'd11:   cw = '{OpFallback, CondNext,     '0};
      4'd12:   cw = '{OpEntry,    CondNext,     '0};
      4'd13:   cw = '{OpEmit,     CondWaitOut,  '0};
      default: cw = '{OpNop,      CondJump,     '0};
    endcase
  end

  always_comb begin
    case (cw.cond)
      CondWaitItem: hold = !status_i.item_full;
      CondWaitDiv:  hold = status_i.div_busy;
      CondWaitOut:  hold = status_i.out_blocked;
      default:      hold = 1'b0;
    endcase
    if (hold) begin
      step_nxt = step_r;
    end else if (cw.cond == CondJump) begin
      step_nxt = cw.target;
    end else begin
      step_nxt = step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else begin
      step_r <= step_nxt;
    end
  end

  assign op_o = cw.op;

  `ASSERT_ON(a_seq_step_range, step_r <= LastStep, "Step counter left the program.")

endmodule

// ===== src/mains_voltage_frequency_qualifier_top.sv =====
// Top level of the mains voltage and frequency qualifier: ports, configuration
// registers, item registers and the datapath. Depends on mvfq_pkg, mvfq_seq,
// mvfq_div and assert_macros.svh.
//
// One item per mains half-cycle gives one result. The frequency and the mean
// each pass through the shared divider, which gives one quotient bit a cycle.
// The microcode program has steps for the item wait, the tick, the divider
// starts and loads, gain, filtering, window checks, the fallback check, the
// entry delay, the emit and the jump back to the item wait. A stalled output
// register holds the program at the emit step until the register drains. The
// next item is taken the cycle after the result is loaded into the output
// register, so the block takes no new item before the last one has its result.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mains_voltage_frequency_qualifier_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  mvfq_pkg::in_t                 in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output mvfq_pkg::out_t                out_item,
  input  logic                          cfg_we,
  input  logic [mvfq_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [mvfq_pkg::CfgW-1:0]     cfg_wdata
);
  import mvfq_pkg::*;

  logic [CfgW-1:0]  ups_cut_r, ups_cut_nxt, ups_rec_r, ups_rec_nxt;
  logic [CfgW-1:0]  inv_cut_r, inv_cut_nxt, inv_rec_r, inv_rec_nxt;
  logic [CfgW-1:0]  extra_r, extra_nxt;
  logic [GainW-1:0] gain_r, gain_nxt;

  in_t              item_r, item_nxt;
  logic             item_full_r, item_full_nxt;
  out_t             out_item_r, out_item_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [VoltW-1:0] filt_r, filt_nxt;
  logic             good_r, good_nxt;
  logic [RecW-1:0]  rec_r, rec_nxt;
  logic [EdcW-1:0]  edc_r, edc_nxt;
  logic             on_r, on_nxt;
  logic             drop_r, drop_nxt;
  logic [FreqW-1:0] freq_r, freq_nxt;
  logic [VsumW-1:0] mean_r, mean_nxt;
  logic [ProdW-1:0] prod_r, prod_nxt;

  op_t              op;
  seq_status_t      status;
  logic             out_blocked;
  logic             emit_fire;
  logic             div_start;
  logic [VsumW-1:0] div_dividend;
  logic [PerW-1:0]  div_divisor;
  logic             div_busy;
  logic [VsumW-1:0] div_quot;

  logic [ProdW-GainShift-1:0] gained;
  logic [VoltW-1:0] fresh;
  logic [VoltW:0]   avg_sum;
  logic [VoltW-1:0] cut_lo, cut_hi, rec_lo, rec_hi, fb_vlo, fb_vhi;
  logic [FreqW-1:0] fcut_lo, fcut_hi, frec_lo, frec_hi, fb_flo, fb_fhi;
  logic             win_incl, win_strict, fb_pass;
  logic [EdcW-1:0]  edc_limit;
  logic             ups;

  assign out_blocked        = out_valid_r && out_stall;
  assign emit_fire          = (op == OpEmit) && !out_blocked;
  assign status.item_full   = item_full_r;
  assign status.div_busy    = div_busy;
  assign status.out_blocked = out_blocked;

  mvfq_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .status_i (status),
    .op_o     (op)
  );

  assign div_start    = (op == OpDivFreq) || (op == OpDivMean);
  assign div_dividend = (op == OpDivFreq) ? FreqNumerator : item_r.voltage_sum;
  assign div_divisor  = (op == OpDivFreq) ? item_r.half_period
                                          : {{(PerW-CntW){1'b0}}, item_r.sample_count};

  mvfq_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quot_o     (div_quot)
  );

  always_comb begin
    ups_cut_nxt = ups_cut_r;
    ups_rec_nxt = ups_rec_r;
    inv_cut_nxt = inv_cut_r;
    inv_rec_nxt = inv_rec_r;
    extra_nxt   = extra_r;
    gain_nxt    = gain_r;
    if (cfg_we) begin
      case (cfg_index)
        RegUpsCut: ups_cut_nxt = cfg_wdata;
        RegUpsRec: ups_rec_nxt = cfg_wdata;
        RegInvCut: inv_cut_nxt = cfg_wdata;
        RegInvRec: inv_rec_nxt = cfg_wdata;
        RegExtra:  extra_nxt   = cfg_wdata;
        RegGain:   gain_nxt    = cfg_wdata[GainW-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    ups = !item_r.inverter_select;
    if (!item_r.switch_on) begin
      cut_lo  = extra_r[15:0];
      cut_hi  = inv_cut_r[31:16];
      rec_lo  = extra_r[31:16];
      rec_hi  = inv_rec_r[31:16];
      fcut_lo = WideCutFLo;
      fcut_hi = WideCutFHi;
      frec_lo = WideRecFLo;
      frec_hi = WideRecFHi;
    end else if (!ups) begin
      cut_lo  = inv_cut_r[15:0];
      cut_hi  = inv_cut_r[31:16];
      rec_lo  = inv_rec_r[15:0];
      rec_hi  = inv_rec_r[31:16];
      fcut_lo = WideCutFLo;
      fcut_hi = WideCutFHi;
      frec_lo = WideRecFLo;
      frec_hi = WideRecFHi;
    end else begin
      cut_lo  = ups_cut_r[15:0];
      cut_hi  = ups_cut_r[31:16];
      rec_lo  = ups_rec_r[15:0];
      rec_hi  = ups_rec_r[31:16];
      fcut_lo = UpsCutFLo;
      fcut_hi = UpsCutFHi;
      frec_lo = UpsRecFLo;
      frec_hi = UpsRecFHi;
    end
    if (ups && item_r.switch_condition) begin
      fb_vlo = NarrowFbVLo;
      fb_vhi = NarrowFbVHi;
      fb_flo = UpsCutFLo;
      fb_fhi = UpsCutFHi;
    end else begin
      fb_vlo = WideFbVLo;
      fb_vhi = WideFbVHi;
      fb_flo = WideCutFLo;
      fb_fhi = WideCutFHi;
    end
    win_incl   = !(filt_r < cut_lo || filt_r > cut_hi || freq_r < fcut_lo || freq_r > fcut_hi);
    win_strict = (filt_r > rec_lo) && (filt_r < rec_hi) && (freq_r > frec_lo) && (freq_r < frec_hi);
    fb_pass    = (filt_r > fb_vlo) && (filt_r < fb_vhi) && (freq_r > fb_flo) && (freq_r < fb_fhi);
    edc_limit  = ups ? UpsLimit : InvLimit;
  end

  always_comb begin
    gained  = prod_r[ProdW-1:GainShift];
    fresh   = (gained[ProdW-GainShift-1:VoltW] != '0) ? '1 : gained[VoltW-1:0];
    avg_sum = {1'b0, fresh} + {1'b0, filt_r};

    filt_nxt = filt_r;
    good_nxt = good_r;
    rec_nxt  = rec_r;
    edc_nxt  = edc_r;
    on_nxt   = on_r;
    drop_nxt = drop_r;
    freq_nxt = freq_r;
    mean_nxt = mean_r;
    prod_nxt = prod_r;

    case (op)
      OpTick: begin
        if (item_r.second_tick) begin
          if (rec_r != RecMax) rec_nxt = rec_r + 1'b1;
          if (edc_r != EdcMax) edc_nxt = edc_r + 1'b1;
        end
      end
      OpLoadFreq: begin
        freq_nxt = (item_r.half_period == '0) ? '0 : div_quot[FreqW-1:0];
      end
      OpLoadMean: begin
        mean_nxt = (item_r.sample_count == '0) ? '0 : div_quot;
      end
      OpGain: begin
        prod_nxt = ProdW'(mean_r) * ProdW'(gain_r);
      end
      OpFilter: begin
        filt_nxt = (item_r.live_half_period > AbsentPeriod) ? '0 : avg_sum[VoltW:1];
      end
      OpWindow: begin
        good_nxt = good_r ? win_incl : win_strict;
      end
      OpFallback: begin
        if (!good_r) begin
          if (fb_pass) begin
            if (rec_r > RecoveryWait) good_nxt = 1'b1;
          end else begin
            rec_nxt = '0;
          end
        end
      end
      OpEntry: begin
        drop_nxt = 1'b0;
        if (good_r) begin
          rec_nxt = '0;
          if (edc_r > edc_limit) begin
            edc_nxt = EdcReload;
            on_nxt  = 1'b1;
          end else if (ups) begin
            on_nxt   = 1'b0;
            drop_nxt = 1'b1;
          end
        end else begin
          edc_nxt = '0;
          on_nxt  = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    item_nxt      = item_r;
    item_full_nxt = item_full_r;
    if (in_valid && !item_full_r) begin
      item_nxt      = in_item;
      item_full_nxt = 1'b1;
    end else if (emit_fire) begin
      item_full_nxt = 1'b0;
    end

    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r;
    if (emit_fire) begin
      out_item_nxt.voltage_reading   = filt_r;
      out_item_nxt.frequency_reading = freq_r;
      out_item_nxt.mains_good        = good_r;
      out_item_nxt.mains_on          = on_r;
      out_item_nxt.drop_to_inverter  = drop_r;
      out_valid_nxt                  = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ups_cut_r   <= UpsCutReset;
      ups_rec_r   <= UpsRecReset;
      inv_cut_r   <= InvCutReset;
      inv_rec_r   <= InvRecReset;
      extra_r     <= ExtraReset;
      gain_r      <= GainReset;
      item_full_r <= 1'b0;
      out_valid_r <= 1'b0;
      filt_r      <= '0;
      good_r      <= 1'b0;
      rec_r       <= '0;
      edc_r       <= '0;
      on_r        <= 1'b0;
    end else begin
      ups_cut_r   <= ups_cut_nxt;
      ups_rec_r   <= ups_rec_nxt;
      inv_cut_r   <= inv_cut_nxt;
      inv_rec_r   <= inv_rec_nxt;
      extra_r     <= extra_nxt;
      gain_r      <= gain_nxt;
      item_full_r <= item_full_nxt;
      out_valid_r <= out_valid_nxt;
      filt_r      <= filt_nxt;
      good_r      <= good_nxt;
      rec_r       <= rec_nxt;
      edc_r       <= edc_nxt;
      on_r        <= on_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    out_item_r <= out_item_nxt;
    drop_r     <= drop_nxt;
    freq_r     <= freq_nxt;
    mean_r     <= mean_nxt;
    prod_r     <= prod_nxt;
  end

  assign in_stall  = item_full_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `ASSERT_ON(a_top_out_from_emit, $rose(out_valid_r) |-> $past(emit_fire), "Result loaded outside the emit step.")
  `ASSERT_ON(a_top_good_clears_rec, (emit_fire && good_r) |-> (rec_r == '0), "Recovery count left set while good.")
  `ASSERT_ON(a_top_on_needs_good, (emit_fire && on_r) |-> good_r, "Mains on raised without mains good.")

endmodule
